// ===== rtl/drgu_pkg.sv =====
`default_nettype none

package drgu_pkg;

  localparam int unsigned CoordW = 32;
  localparam int unsigned AreaW  = 2 * CoordW;

  typedef enum logic [1:0] {
    CMD_INTERSECT = 2'd0,
    CMD_MERGE     = 2'd1,
    CMD_UPDATE    = 2'd2,
    CMD_FULL      = 2'd3
  } cmd_e;

  typedef struct packed {
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
    logic [CoordW-1:0] w;
    logic [CoordW-1:0] h;
  } rect_t;

  // Geometry results of one item, before any area arithmetic.
  typedef struct packed {
    cmd_e              cmd;
    logic              ok;
    rect_t             res;
    logic [CoordW-1:0] dst_x;
    logic [CoordW-1:0] dst_y;
    logic              ov_ok;
    logic [CoordW-1:0] a_w;
    logic [CoordW-1:0] a_h;
    logic [CoordW-1:0] b_w;
    logic [CoordW-1:0] b_h;
    logic [CoordW-1:0] ov_w;
    logic [CoordW-1:0] ov_h;
  } geo_t;

  // Item after the area products.
  typedef struct packed {
    cmd_e              cmd;
    logic              ok;
    rect_t             res;
    logic [CoordW-1:0] dst_x;
    logic [CoordW-1:0] dst_y;
    logic [AreaW-1:0]  area_a;
    logic [AreaW-1:0]  area_b;
    logic [AreaW-1:0]  area_ov;
    logic [AreaW-1:0]  area_bb;
  } area_t;

endpackage

`default_nettype wire

// ===== rtl/dirty_rect_geometry_unit.sv =====
// Rectangle unit for the scanout path: intersect, exact merge, update and
// full update of two rectangles A and B.
// Input channel: in_valid_i / in_stall_o with cmd_i and the eight rectangle
// fields. An item is taken at a clock edge where in_valid_i is high and
// in_stall_o is low.
// Output channel: out_valid_o / out_stall_i with ok_o, the result rectangle
// and the destination origin. Every item gives exactly one result.
// An item passes four stages: the input register, the edge and overlap
// stage, the area multipliers and the merge area check with the output
// register. Throughput: one item per cycle while out_stall_i is low.
// No state is kept between items.
// While out_stall_i is high the result holds; the stages behind it still
// fill up, so in_stall_o rises only once all four stages hold an item.
// Reset empties the pipeline; no result is shown until a new item enters.
`default_nettype none

module dirty_rect_geometry_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output      logic        in_stall_o,
  input  wire logic [1:0]  cmd_i,
  input  wire logic [31:0] a_x_i,
  input  wire logic [31:0] a_y_i,
  input  wire logic [31:0] a_width_i,
  input  wire logic [31:0] a_height_i,
  input  wire logic [31:0] b_x_i,
  input  wire logic [31:0] b_y_i,
  input  wire logic [31:0] b_width_i,
  input  wire logic [31:0] b_height_i,
  output      logic        out_valid_o,
  input  wire logic        out_stall_i,
  output      logic        ok_o,
  output      logic [31:0] res_x_o,
  output      logic [31:0] res_y_o,
  output      logic [31:0] res_width_o,
  output      logic [31:0] res_height_o,
  output      logic [31:0] dst_x_o,
  output      logic [31:0] dst_y_o
);

  logic v_in_q, v_geo_q, v_area_q, v_out_q;
  logic adv_in, adv_geo, adv_area, adv_out;

  drgu_pkg::cmd_e  cmd_q;
  drgu_pkg::rect_t a_q, b_q;
  drgu_pkg::geo_t  geo_d, geo_q;
  drgu_pkg::area_t area_d, area_q;

  logic [drgu_pkg::AreaW-1:0]  uni;
  logic                        ok_d;
  drgu_pkg::rect_t             res_d, res_q;
  logic [drgu_pkg::CoordW-1:0] dst_x_d, dst_y_d, dst_x_q, dst_y_q;
  logic                        ok_q;

  // A stage may load when it is empty or when its contents move on.
  assign adv_out  = !v_out_q || !out_stall_i;
  assign adv_area = !v_area_q || adv_out;
  assign adv_geo  = !v_geo_q || adv_area;
  assign adv_in   = !v_in_q || adv_geo;

  assign in_stall_o = !adv_in;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_in_q   <= 1'b0;
      v_geo_q  <= 1'b0;
      v_area_q <= 1'b0;
      v_out_q  <= 1'b0;
    end else begin
      if (adv_in) v_in_q <= in_valid_i;
      if (adv_geo) v_geo_q <= v_in_q;
      if (adv_area) v_area_q <= v_geo_q;
      if (adv_out) v_out_q <= v_area_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_in && in_valid_i) begin
      cmd_q <= drgu_pkg::cmd_e'(cmd_i);
      a_q   <= '{x: a_x_i, y: a_y_i, w: a_width_i, h: a_height_i};
      b_q   <= '{x: b_x_i, y: b_y_i, w: b_width_i, h: b_height_i};
    end
    if (adv_geo && v_in_q) geo_q <= geo_d;
    if (adv_area && v_geo_q) area_q <= area_d;
    if (adv_out && v_area_q) begin
      ok_q    <= ok_d;
      res_q   <= res_d;
      dst_x_q <= dst_x_d;
      dst_y_q <= dst_y_d;
    end
  end

  drgu_geom u_geom (
    .cmd_i (cmd_q),
    .a_i   (a_q),
    .b_i   (b_q),
    .geo_o (geo_d)
  );

  always_comb begin
    area_d.cmd     = geo_q.cmd;
    area_d.ok      = geo_q.ok;
    area_d.res     = geo_q.res;
    area_d.dst_x   = geo_q.dst_x;
    area_d.dst_y   = geo_q.dst_y;
    area_d.area_a  = geo_q.a_w * geo_q.a_h;
    area_d.area_b  = geo_q.b_w * geo_q.b_h;
    area_d.area_ov = geo_q.ov_ok ? geo_q.ov_w * geo_q.ov_h : '0;
    area_d.area_bb = geo_q.res.w * geo_q.res.h;
  end

  always_comb begin
    uni  = area_q.area_a + area_q.area_b - area_q.area_ov;
    ok_d = area_q.ok;
    if (area_q.cmd == drgu_pkg::CMD_MERGE) begin
      ok_d = area_q.ok && (area_q.area_bb == uni);
    end
    // A failed item shows all fields cleared.
    res_d   = ok_d ? area_q.res : '0;
    dst_x_d = ok_d ? area_q.dst_x : '0;
    dst_y_d = ok_d ? area_q.dst_y : '0;
  end

  assign out_valid_o  = v_out_q;
  assign ok_o         = ok_q;
  assign res_x_o      = res_q.x;
  assign res_y_o      = res_q.y;
  assign res_width_o  = res_q.w;
  assign res_height_o = res_q.h;
  assign dst_x_o      = dst_x_q;
  assign dst_y_o      = dst_y_q;

endmodule

`default_nettype wire

// ===== rtl/drgu_geom.sv =====
`default_nettype none

module drgu_geom (
  input  drgu_pkg::cmd_e  cmd_i,
  input  drgu_pkg::rect_t a_i,
  input  drgu_pkg::rect_t b_i,
  output drgu_pkg::geo_t  geo_o
);

  logic [drgu_pkg::CoordW:0]   a_ex, a_ey, b_ex, b_ey;
  logic [drgu_pkg::CoordW:0]   ov_x2, ov_y2, bb_x2, bb_y2;
  logic [drgu_pkg::CoordW-1:0] ov_x1, ov_y1, bb_x1, bb_y1;
  logic                        a_ok, b_ok, ov_ok;
  drgu_pkg::rect_t             ov, bb;

  always_comb begin
    a_ex = {1'b0, a_i.x} + {1'b0, a_i.w};
    a_ey = {1'b0, a_i.y} + {1'b0, a_i.h};
    b_ex = {1'b0, b_i.x} + {1'b0, b_i.w};
    b_ey = {1'b0, b_i.y} + {1'b0, b_i.h};

    a_ok = (a_i.w != '0) && (a_i.h != '0) && !a_ex[drgu_pkg::CoordW] && !a_ey[drgu_pkg::CoordW];
    b_ok = (b_i.w != '0) && (b_i.h != '0) && !b_ex[drgu_pkg::CoordW] && !b_ey[drgu_pkg::CoordW];

    ov_x1 = (a_i.x > b_i.x) ? a_i.x : b_i.x;
    ov_y1 = (a_i.y > b_i.y) ? a_i.y : b_i.y;
    ov_x2 = (a_ex < b_ex) ? a_ex : b_ex;
    ov_y2 = (a_ey < b_ey) ? a_ey : b_ey;
    ov_ok = a_ok && b_ok && ({1'b0, ov_x1} < ov_x2) && ({1'b0, ov_y1} < ov_y2);

    ov.x = ov_x1;
    ov.y = ov_y1;
    ov.w = ov_x2[drgu_pkg::CoordW-1:0] - ov_x1;
    ov.h = ov_y2[drgu_pkg::CoordW-1:0] - ov_y1;

    // With both inputs valid the bounding box is always valid itself: its far
    // edges fit in 32 bits and its sides are at least as long as A's.
    bb_x1 = (a_i.x < b_i.x) ? a_i.x : b_i.x;
    bb_y1 = (a_i.y < b_i.y) ? a_i.y : b_i.y;
    bb_x2 = (a_ex > b_ex) ? a_ex : b_ex;
    bb_y2 = (a_ey > b_ey) ? a_ey : b_ey;
    bb.x  = bb_x1;
    bb.y  = bb_y1;
    bb.w  = bb_x2[drgu_pkg::CoordW-1:0] - bb_x1;
    bb.h  = bb_y2[drgu_pkg::CoordW-1:0] - bb_y1;

    geo_o.cmd   = cmd_i;
    geo_o.ov_ok = ov_ok;
    geo_o.a_w   = a_i.w;
    geo_o.a_h   = a_i.h;
    geo_o.b_w   = b_i.w;
    geo_o.b_h   = b_i.h;
    geo_o.ov_w  = ov.w;
    geo_o.ov_h  = ov.h;
    geo_o.dst_x = '0;
    geo_o.dst_y = '0;

    case (cmd_i)
      drgu_pkg::CMD_INTERSECT: begin
        geo_o.ok  = ov_ok;
        geo_o.res = ov;
      end
      drgu_pkg::CMD_MERGE: begin
        geo_o.ok  = a_ok && b_ok;
        geo_o.res = bb;
      end
      drgu_pkg::CMD_UPDATE: begin
        geo_o.ok    = ov_ok;
        geo_o.res   = ov;
        geo_o.dst_x = ov.x - a_i.x;
        geo_o.dst_y = ov.y - a_i.y;
      end
      default: begin
        geo_o.ok  = a_ok;
        geo_o.res = a_i;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/drgu_checker.sv =====
`default_nettype none

module drgu_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic        ok_o,
  input wire logic [31:0] res_x_o,
  input wire logic [31:0] res_y_o,
  input wire logic [31:0] res_width_o,
  input wire logic [31:0] res_height_o,
  input wire logic [31:0] dst_x_o,
  input wire logic [31:0] dst_y_o
);

  // A stalled result stays on the port.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // A failed item shows all fields cleared.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !ok_o |-> (res_x_o == '0) && (res_y_o == '0) && (res_width_o == '0)
      && (res_height_o == '0) && (dst_x_o == '0) && (dst_y_o == '0))
    else $error("failed item with nonzero fields");

  // A good result is a valid rectangle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && ok_o |-> (res_width_o != '0) && (res_height_o != '0)
      && ({1'b0, res_x_o} + {1'b0, res_width_o} <= 33'h0_FFFF_FFFF)
      && ({1'b0, res_y_o} + {1'b0, res_height_o} <= 33'h0_FFFF_FFFF))
    else $error("good result is not a valid rectangle");

  // The destination origin never lies beyond the source origin.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && ok_o |-> (dst_x_o <= res_x_o) && (dst_y_o <= res_y_o))
    else $error("destination beyond source origin");

endmodule

bind dirty_rect_geometry_unit drgu_checker u_drgu_checker (.*);

`default_nettype wire

// ===== tb/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [31:0] COORD_MAX       = 32'hFFFF_FFFF;
  localparam int          RANDOM_ITEMS    = 1880;
  localparam int          HOLD_OFF_AT     = 500;
  localparam int          HOLD_OFF_CYCLES = 300;
  localparam int          WATCHDOG_LIMIT  = 3000;
  localparam int          DRAIN_CYCLES    = 8;
  localparam int          MAX_REPORTS     = 100;

  typedef struct packed {
    logic        ok;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] w;
    logic [31:0] h;
    logic [31:0] dst_x;
    logic [31:0] dst_y;
  } scan_res_t;

  typedef struct packed {
    drgu_pkg::cmd_e  cmd;
    drgu_pkg::rect_t a;
    drgu_pkg::rect_t b;
    logic            fixed;
    scan_res_t       want;
  } rect_job_t;

  localparam scan_res_t NO_RESULT = '0;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [1:0]  cmd_i;
  logic [31:0] a_x_i, a_y_i, a_width_i, a_height_i;
  logic [31:0] b_x_i, b_y_i, b_width_i, b_height_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic        ok_o;
  logic [31:0] res_x_o, res_y_o, res_width_o, res_height_o;
  logic [31:0] dst_x_o, dst_y_o;

  // Typed-in expectation that travels with the item on the input port.
  logic        row_fixed;
  scan_res_t   row_want;

  logic        hold_off_req;
  scan_res_t   pending_results[$];
  rect_job_t   directed_jobs[$];
  int          mismatches;
  int          idle_cycles = 0;
  int          burst_left;

  dirty_rect_geometry_unit u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .cmd_i       (cmd_i),
    .a_x_i       (a_x_i),
    .a_y_i       (a_y_i),
    .a_width_i   (a_width_i),
    .a_height_i  (a_height_i),
    .b_x_i       (b_x_i),
    .b_y_i       (b_y_i),
    .b_width_i   (b_width_i),
    .b_height_i  (b_height_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .ok_o        (ok_o),
    .res_x_o     (res_x_o),
    .res_y_o     (res_y_o),
    .res_width_o (res_width_o),
    .res_height_o(res_height_o),
    .dst_x_o     (dst_x_o),
    .dst_y_o     (dst_y_o)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // ---------------------------------------------------------------- geometry

  function automatic drgu_pkg::rect_t rect_of(logic [31:0] x, logic [31:0] y,
                                              logic [31:0] w, logic [31:0] h);
    drgu_pkg::rect_t r;
    r.x = x;
    r.y = y;
    r.w = w;
    r.h = h;
    return r;
  endfunction

  function automatic scan_res_t good_res(logic [31:0] x, logic [31:0] y,
                                         logic [31:0] w, logic [31:0] h,
                                         logic [31:0] dx, logic [31:0] dy);
    scan_res_t s;
    s.ok    = 1'b1;
    s.x     = x;
    s.y     = y;
    s.w     = w;
    s.h     = h;
    s.dst_x = dx;
    s.dst_y = dy;
    return s;
  endfunction

  // The far edges are summed at 33 bits so that a wrap cannot hide an overflow.
  function automatic bit rect_valid(drgu_pkg::rect_t r);
    return r.w != 0 && r.h != 0 &&
           ({1'b0, r.x} + {1'b0, r.w}) <= {1'b0, COORD_MAX} &&
           ({1'b0, r.y} + {1'b0, r.h}) <= {1'b0, COORD_MAX};
  endfunction

  function automatic logic [63:0] rect_area(drgu_pkg::rect_t r);
    return {32'b0, r.w} * {32'b0, r.h};
  endfunction

  function automatic bit rect_overlap(drgu_pkg::rect_t a, drgu_pkg::rect_t b,
                                      output drgu_pkg::rect_t o);
    logic [31:0] x1, y1, x2, y2;
    o = '0;
    if (!rect_valid(a) || !rect_valid(b)) return 1'b0;
    x1 = (a.x > b.x) ? a.x : b.x;
    y1 = (a.y > b.y) ? a.y : b.y;
    x2 = (a.x + a.w < b.x + b.w) ? a.x + a.w : b.x + b.w;
    y2 = (a.y + a.h < b.y + b.h) ? a.y + a.h : b.y + b.h;
    if (x1 >= x2 || y1 >= y2) return 1'b0;
    o = rect_of(x1, y1, x2 - x1, y2 - y1);
    return 1'b1;
  endfunction

  // The bounding box is a merge only when A and B cover it with no hole.
  function automatic bit rect_merge(drgu_pkg::rect_t a, drgu_pkg::rect_t b,
                                    output drgu_pkg::rect_t o);
    drgu_pkg::rect_t bb, ov;
    logic [31:0]     x2, y2;
    logic [63:0]     shared, covered;
    o = '0;
    if (!rect_valid(a) || !rect_valid(b)) return 1'b0;
    bb.x = (a.x < b.x) ? a.x : b.x;
    bb.y = (a.y < b.y) ? a.y : b.y;
    x2   = (a.x + a.w > b.x + b.w) ? a.x + a.w : b.x + b.w;
    y2   = (a.y + a.h > b.y + b.h) ? a.y + a.h : b.y + b.h;
    bb.w = x2 - bb.x;
    bb.h = y2 - bb.y;
    if (!rect_valid(bb)) return 1'b0;
    shared  = rect_overlap(a, b, ov) ? rect_area(ov) : 64'd0;
    covered = rect_area(a) + rect_area(b) - shared;
    if (rect_area(bb) != covered) return 1'b0;
    o = bb;
    return 1'b1;
  endfunction

  function automatic scan_res_t predict_rect_op(drgu_pkg::cmd_e cmd, drgu_pkg::rect_t a,
                                                drgu_pkg::rect_t b);
    drgu_pkg::rect_t r;
    bit              good;
    scan_res_t       s;
    s = NO_RESULT;
    r = '0;
    case (cmd)
      drgu_pkg::CMD_INTERSECT: good = rect_overlap(a, b, r);
      drgu_pkg::CMD_MERGE:     good = rect_merge(a, b, r);
      drgu_pkg::CMD_UPDATE:    good = rect_overlap(a, b, r);
      default: begin
        good = rect_valid(a);
        r    = a;
      end
    endcase
    if (good) begin
      s = good_res(r.x, r.y, r.w, r.h, 32'd0, 32'd0);
      if (cmd == drgu_pkg::CMD_UPDATE) begin
        s.dst_x = r.x - a.x;
        s.dst_y = r.y - a.y;
      end
    end
    return s;
  endfunction

  // ---------------------------------------------------------------- stimulus

  task automatic add_row(drgu_pkg::cmd_e cmd, drgu_pkg::rect_t a, drgu_pkg::rect_t b,
                         logic fixed, scan_res_t want);
    rect_job_t j;
    j.cmd   = cmd;
    j.a     = a;
    j.b     = b;
    j.fixed = fixed;
    j.want  = want;
    directed_jobs.push_back(j);
  endtask

  function automatic logic [31:0] edge_val();
    case ($urandom_range(0, 5))
      0:       return 32'd0;
      1:       return 32'd1;
      2:       return COORD_MAX;
      3:       return COORD_MAX - 1;
      4:       return 32'h8000_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic drgu_pkg::rect_t rand_rect();
    drgu_pkg::rect_t r;
    case ($urandom_range(0, 3))
      0, 1: begin
        r.x = $urandom_range(0, 255);
        r.y = $urandom_range(0, 255);
        r.w = $urandom_range(1, 64);
        r.h = $urandom_range(1, 64);
      end
      2: begin
        r.x = $urandom;
        r.y = $urandom;
        r.w = $urandom_range(1, COORD_MAX - r.x);
        r.h = $urandom_range(1, COORD_MAX - r.y);
      end
      default: begin
        r.x = $urandom_range(0, 15);
        r.y = $urandom_range(0, 15);
        r.w = COORD_MAX - r.x - $urandom_range(0, 15);
        r.h = COORD_MAX - r.y - $urandom_range(0, 15);
      end
    endcase
    return r;
  endfunction

  // B is placed against A so that overlaps, exact merges and near misses are common.
  function automatic drgu_pkg::rect_t partner_rect(drgu_pkg::rect_t a);
    drgu_pkg::rect_t b;
    b = rand_rect();
    case ($urandom_range(0, 6))
      0: ;
      1: begin
        b.x = a.x + $urandom_range(0, a.w - 1);
        b.y = a.y + $urandom_range(0, a.h - 1);
      end
      2: begin
        b.x = a.x + a.w;
        b.y = a.y;
        b.h = a.h;
      end
      3: begin
        b.x = a.x;
        b.y = a.y + a.h;
        b.w = a.w;
      end
      4: b = a;
      5: begin
        b.x = a.x + a.w;
        b.y = a.y + $urandom_range(0, 1);
        b.h = a.h + $urandom_range(0, 1);
      end
      default: begin
        b.x = a.x + $urandom_range(0, a.w - 1);
        b.y = a.y + $urandom_range(0, a.h - 1);
        b.w = $urandom_range(1, a.x + a.w - b.x);
        b.h = $urandom_range(1, a.y + a.h - b.y);
      end
    endcase
    return b;
  endfunction

  function automatic rect_job_t rand_job();
    rect_job_t       j;
    drgu_pkg::rect_t t;
    j.cmd   = drgu_pkg::cmd_e'($urandom_range(0, 3));
    j.fixed = 1'b0;
    j.want  = NO_RESULT;
    case ($urandom_range(0, 7))
      0: begin
        j.a = rect_of($urandom, $urandom, $urandom, $urandom);
        j.b = rect_of($urandom, $urandom, $urandom, $urandom);
      end
      1: begin
        j.a = rect_of(edge_val(), edge_val(), edge_val(), edge_val());
        j.b = rect_of(edge_val(), edge_val(), edge_val(), edge_val());
      end
      default: begin
        j.a = rand_rect();
        j.b = partner_rect(j.a);
        if ($urandom_range(0, 1)) begin
          t   = j.a;
          j.a = j.b;
          j.b = t;
        end
      end
    endcase
    // About one job in sixteen, of any kind, gets one field broken.
    if ($urandom_range(0, 15) == 0) begin
      case ($urandom_range(0, 7))
        0: j.a.x = edge_val();
        1: j.a.y = edge_val();
        2: j.a.w = edge_val();
        3: j.a.h = edge_val();
        4: j.b.x = edge_val();
        5: j.b.y = edge_val();
        6: j.b.w = edge_val();
        default: j.b.h = edge_val();
      endcase
    end
    return j;
  endfunction

  // Offers one item and returns at the edge where it is taken. A gap is
  // inserted in front of the item whenever a burst runs out.
  task automatic send_job(rect_job_t j);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                              : $urandom_range(1, 20);
      gap = $urandom_range(1, 15);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    burst_left--;
    in_valid_i <= 1'b1;
    cmd_i      <= j.cmd;
    a_x_i      <= j.a.x;
    a_y_i      <= j.a.y;
    a_width_i  <= j.a.w;
    a_height_i <= j.a.h;
    b_x_i      <= j.b.x;
    b_y_i      <= j.b.y;
    b_width_i  <= j.b.w;
    b_height_i <= j.b.h;
    row_fixed  <= j.fixed;
    row_want   <= j.want;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------- checking

  task automatic report_mismatch(string msg);
    if (mismatches < MAX_REPORTS) $display("%0t mismatch: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic compare_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %h, expected %h", name, got, want));
  endtask

  always @(posedge clk_i) begin
    scan_res_t want;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        if (row_fixed) pending_results.push_back(row_want);
        else pending_results.push_back(predict_rect_op(drgu_pkg::cmd_e'(cmd_i),
            rect_of(a_x_i, a_y_i, a_width_i, a_height_i),
            rect_of(b_x_i, b_y_i, b_width_i, b_height_i)));
      end
      if (out_valid_o && !out_stall_i) begin
        if (pending_results.size() == 0) begin
          report_mismatch("result with no item outstanding");
        end else begin
          want = pending_results.pop_front();
          compare_field("ok", {31'b0, ok_o}, {31'b0, want.ok});
          compare_field("res_x", res_x_o, want.x);
          compare_field("res_y", res_y_o, want.y);
          compare_field("res_width", res_width_o, want.w);
          compare_field("res_height", res_height_o, want.h);
          compare_field("dst_x", dst_x_o, want.dst_x);
          compare_field("dst_y", dst_y_o, want.dst_y);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: no item moved for %0d cycles", idle_cycles);
      $display("** dirty_rect_geometry_unit: FAILED **");
      $finish;
    end
  end

  // ---------------------------------------------------------------- receiver

  initial begin
    int  mode, seg, per;
    bit  hold_done;
    out_stall_i = 1'b0;
    hold_done   = 1'b0;
    forever begin
      mode = $urandom_range(0, 3);
      seg  = $urandom_range(20, 120);
      per  = $urandom_range(2, 6);
      for (int i = 0; i < seg; i++) begin
        @(posedge clk_i);
        if (hold_off_req && !hold_done) begin
          // Long hold-off: the pipeline fills and the input has to stall.
          hold_done = 1'b1;
          out_stall_i <= 1'b1;
          repeat (HOLD_OFF_CYCLES) @(posedge clk_i);
        end else begin
          case (mode)
            0:       out_stall_i <= 1'b0;
            1:       out_stall_i <= ($urandom_range(0, 3) == 0);
            2:       out_stall_i <= ($urandom_range(0, 3) != 0);
            default: out_stall_i <= ((i % per) == 0);
          endcase
        end
      end
    end
  end

  // ---------------------------------------------------------------- main

  initial begin
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    cmd_i        = '0;
    a_x_i        = '0;
    a_y_i        = '0;
    a_width_i    = '0;
    a_height_i   = '0;
    b_x_i        = '0;
    b_y_i        = '0;
    b_width_i    = '0;
    b_height_i   = '0;
    row_fixed    = 1'b0;
    row_want     = NO_RESULT;
    hold_off_req = 1'b0;
    mismatches   = 0;
    burst_left   = 0;

    // Invalid rectangles, touching edges and coordinates at the top of the range.
    add_row(drgu_pkg::CMD_INTERSECT, rect_of(0, 0, 0, 5), rect_of(0, 0, 5, 5), 1'b1,
            NO_RESULT);
    add_row(drgu_pkg::CMD_INTERSECT, rect_of(0, 0, 5, 5), rect_of(0, 0, 5, 0), 1'b1,
            NO_RESULT);
    add_row(drgu_pkg::CMD_INTERSECT, rect_of(1, 0, COORD_MAX, 5), rect_of(0, 0, 5, 5),
            1'b1, NO_RESULT);
    add_row(drgu_pkg::CMD_INTERSECT, rect_of(0, 0, COORD_MAX, COORD_MAX),
            rect_of(10, 10, 5, 5), 1'b1, good_res(10, 10, 5, 5, 0, 0));
    add_row(drgu_pkg::CMD_INTERSECT, rect_of(0, 0, 10, 10), rect_of(10, 0, 10, 10), 1'b1,
            NO_RESULT);
    add_row(drgu_pkg::CMD_INTERSECT, rect_of(3, 4, 10, 10), rect_of(8, 1, 20, 6), 1'b0,
            NO_RESULT);
    add_row(drgu_pkg::CMD_INTERSECT, rect_of(COORD_MAX - 1, COORD_MAX - 1, 1, 1),
            rect_of(COORD_MAX - 1, COORD_MAX - 1, 1, 1), 1'b1,
            good_res(COORD_MAX - 1, COORD_MAX - 1, 1, 1, 0, 0));
    add_row(drgu_pkg::CMD_INTERSECT, rect_of(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX),
            rect_of(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX), 1'b1, NO_RESULT);
    add_row(drgu_pkg::CMD_MERGE, rect_of(0, 0, 10, 10), rect_of(10, 0, 10, 10), 1'b1,
            good_res(0, 0, 20, 10, 0, 0));
    add_row(drgu_pkg::CMD_MERGE, rect_of(0, 0, 10, 10), rect_of(5, 5, 10, 10), 1'b1,
            NO_RESULT);
    add_row(drgu_pkg::CMD_MERGE, rect_of(4, 4, 6, 6), rect_of(4, 4, 6, 6), 1'b1,
            good_res(4, 4, 6, 6, 0, 0));
    add_row(drgu_pkg::CMD_MERGE, rect_of(0, 0, 10, 10), rect_of(2, 2, 3, 3), 1'b1,
            good_res(0, 0, 10, 10, 0, 0));
    add_row(drgu_pkg::CMD_MERGE, rect_of(0, 0, 10, 10), rect_of(11, 0, 10, 10), 1'b1,
            NO_RESULT);
    add_row(drgu_pkg::CMD_MERGE, rect_of(0, 0, 10, 10), rect_of(0, 0, 0, 10), 1'b1,
            NO_RESULT);
    add_row(drgu_pkg::CMD_MERGE, rect_of(0, 0, COORD_MAX, COORD_MAX - 1),
            rect_of(0, COORD_MAX - 1, COORD_MAX, 1), 1'b0, NO_RESULT);
    // The two areas together wrap past 64 bits.
    add_row(drgu_pkg::CMD_MERGE, rect_of(0, 0, COORD_MAX, COORD_MAX),
            rect_of(0, 0, COORD_MAX, COORD_MAX), 1'b0, NO_RESULT);
    add_row(drgu_pkg::CMD_UPDATE, rect_of(100, 200, 50, 60), rect_of(120, 210, 100, 100),
            1'b0, NO_RESULT);
    add_row(drgu_pkg::CMD_UPDATE, rect_of(0, 0, 10, 10), rect_of(20, 20, 5, 5), 1'b1,
            NO_RESULT);
    add_row(drgu_pkg::CMD_UPDATE, rect_of(0, 0, 10, 0), rect_of(0, 0, 5, 5), 1'b1,
            NO_RESULT);
    add_row(drgu_pkg::CMD_UPDATE, rect_of(COORD_MAX - 20, COORD_MAX - 30, 20, 30),
            rect_of(0, 0, COORD_MAX, COORD_MAX), 1'b0, NO_RESULT);
    add_row(drgu_pkg::CMD_FULL, rect_of(7, 9, 3, 4),
            rect_of(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX), 1'b1,
            good_res(7, 9, 3, 4, 0, 0));
    add_row(drgu_pkg::CMD_FULL, rect_of(7, 9, 0, 4), rect_of(0, 0, 5, 5), 1'b1,
            NO_RESULT);
    add_row(drgu_pkg::CMD_FULL, rect_of(0, COORD_MAX, 5, 1), rect_of(0, 0, 5, 5), 1'b1,
            NO_RESULT);
    add_row(drgu_pkg::CMD_FULL, rect_of(COORD_MAX - 1, 0, 1, COORD_MAX),
            rect_of(0, 0, 0, 0), 1'b1, good_res(COORD_MAX - 1, 0, 1, COORD_MAX, 0, 0));
    add_row(drgu_pkg::CMD_FULL, rect_of(0, 0, 0, 0), rect_of(0, 0, 0, 0), 1'b1,
            NO_RESULT);

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_jobs[i]) send_job(directed_jobs[i]);
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == HOLD_OFF_AT) hold_off_req <= 1'b1;
      send_job(rand_job());
    end
    in_valid_i <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("** dirty_rect_geometry_unit: PASSED **");
    end else begin
      $display("** dirty_rect_geometry_unit: FAILED **");
    end
    $finish;
  end

endmodule
